// File: hw/rtl/rgbds_pkg.sv
// Shared types and constants for the RGBA8 2x2 box downsampler.
`timescale 1ns / 1ps
package rgbds_pkg;

    localparam int NUM_LANES = 4;
    localparam int CH_W      = 8;
    localparam int PAIR_W    = CH_W + 1;
    localparam int LINE_W    = NUM_LANES * PAIR_W;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] texel_c3;
        logic [CH_W-1:0] texel_c2;
        logic [CH_W-1:0] texel_c1;
        logic [CH_W-1:0] texel_c0;
    } texel_t;

    typedef struct packed {
        logic [CH_W-1:0] out_c3;
        logic [CH_W-1:0] out_c2;
        logic [CH_W-1:0] out_c1;
        logic [CH_W-1:0] out_c0;
        logic            level_done;
    } result_t;

    // Per-transaction decisions from the position tracker
    typedef struct packed {
        logic w_one;     // source width is one column
        logic h_one;     // source height is one row
        logic hold_en;   // capture this pixel as the left member of a pair
        logic line_we;   // store the pair sum for the row below
        logic emit;      // this transaction produces a result
        logic last;      // result closes the level
    } step_t;

endpackage

// File: hw/rtl/rgbds_ctrl.sv
// Size registers and raster position tracker for the 2x2 downsampler.
`timescale 1ns / 1ps
module rgbds_ctrl #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int AW         = 11
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rgbds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rgbds_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                              advance,
    output rgbds_pkg::step_t                  step,
    output logic [AW-1:0]                     line_addr
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [rgbds_pkg::CFG_W-1:0] width_reg;
    logic [rgbds_pkg::CFG_W-1:0] height_reg;
    logic [XW-1:0]               col_reg;
    logic [XW-1:0]               col_next;
    logic [YW-1:0]               row_reg;
    logic [YW-1:0]               row_next;

    logic [31:0]   w_clamp;
    logic [31:0]   h_clamp;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [XW-1:0] x_eff;
    logic [YW-1:0] y_eff;
    logic [31:0]   x_half;
    logic          w_one;
    logic          h_one;
    logic          last_x;
    logic          last_y;
    logic          have_pair;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rgbds_pkg::CFG_W'(1);
            height_reg <= rgbds_pkg::CFG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rgbds_pkg::REG_SRC_WIDTH:  width_reg  <= cfg_wdata;
                rgbds_pkg::REG_SRC_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp sizes: zero acts as one, anything beyond the maximum as the maximum
    always_comb
    begin
        if (width_reg == '0)
            w_clamp = 32'd1;
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_clamp = 32'(MAX_WIDTH);
        else
            w_clamp = 32'(width_reg);
        if (height_reg == '0)
            h_clamp = 32'd1;
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            h_clamp = 32'(MAX_HEIGHT);
        else
            h_clamp = 32'(height_reg);
    end

    assign w_eff = w_clamp[WW-1:0];
    assign h_eff = h_clamp[HW-1:0];
    assign w_one = (w_eff == WW'(1));
    assign h_one = (h_eff == HW'(1));

    // Wrap a counter that sits beyond a size changed mid-level
    assign x_eff = (32'(col_reg) >= 32'(w_eff)) ? '0 : col_reg;
    assign y_eff = (32'(row_reg) >= 32'(h_eff)) ? '0 : row_reg;

    assign last_x    = (32'(x_eff) + 32'd1 == 32'(w_eff));
    assign last_y    = (32'(y_eff) + 32'd1 == 32'(h_eff));
    assign x_half    = 32'(x_eff) >> 1;
    assign have_pair = w_one || x_eff[0];

    assign line_addr = w_one ? '0 : x_half[AW-1:0];

    always_comb
    begin
        step.w_one   = w_one;
        step.h_one   = h_one;
        step.hold_en = !w_one && !x_eff[0] && !last_x;
        step.line_we = have_pair && !h_one && !y_eff[0] && !last_y;
        step.emit    = have_pair && (h_one || y_eff[0]);
        step.last    = (h_one || (32'(y_eff) + 32'd1 == 32'(h_eff & ~HW'(1))))
                       && (w_one || (x_half + 32'd1 == 32'(w_eff >> 1)));
    end

    always_comb
    begin
        col_next = last_x ? '0 : x_eff + XW'(1);
        if (!last_x)
            row_next = y_eff;
        else if (last_y)
            row_next = '0;
        else
            row_next = y_eff + YW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// File: hw/rtl/rgbds_lane.sv
// One byte channel: horizontal pair sum, vertical sum and truncated mean.
`timescale 1ns / 1ps
module rgbds_lane (
    input  logic                           clk,
    input  logic                           w_one,
    input  logic [rgbds_pkg::CH_W-1:0]     texel_b,
    input  logic [rgbds_pkg::CH_W-1:0]     held_b,
    output logic [rgbds_pkg::PAIR_W-1:0]   pair,
    input  logic                           load_pair,
    input  logic                           load_avg,
    input  logic                           dbl,
    input  logic [rgbds_pkg::PAIR_W-1:0]   line_pair,
    output logic [rgbds_pkg::CH_W-1:0]     avg
);

    logic [rgbds_pkg::PAIR_W-1:0] pair_reg;
    logic [rgbds_pkg::PAIR_W:0]   block_sum;
    logic [rgbds_pkg::CH_W-1:0]   avg_reg;

    // A single column pairs the pixel with itself
    assign pair = w_one ? {texel_b, 1'b0}
                        : rgbds_pkg::PAIR_W'(texel_b) + rgbds_pkg::PAIR_W'(held_b);

    assign block_sum = dbl ? {pair_reg, 1'b0}
                           : (rgbds_pkg::PAIR_W+1)'(pair_reg)
                             + (rgbds_pkg::PAIR_W+1)'(line_pair);

    always_ff @(posedge clk)
    begin
        if (load_pair)
            pair_reg <= pair;
        if (load_avg)
            avg_reg <= block_sum[rgbds_pkg::PAIR_W:2];
    end

    assign avg = avg_reg;

endmodule

// File: hw/rtl/rgba8_box_downsample_2x2_unit.sv
// Top level of the streaming RGBA8 2x2 box downsampler.
`timescale 1ns / 1ps
// Reduces one mip level: source RGBA8 pixels enter in raster order, one per
// cycle, and the block delivers the max(w/2,1) by max(h/2,1) level in raster
// order, each channel the truncated mean of a 2x2 block. A pixel is taken
// every clock cycle as long as the output side keeps up; the single-port line
// store is read on every pixel, also written on some, and never holds the input off.
// With the consumer stalled, one result in stage one and one in the output
// register fill the block and the input stalls until the output drains.
// At a result's accepting edge, its pair sum and line store read are registered
// in stage one; the lane sum lands in the output register when that register
// advances. The line store holds MAX_WIDTH/2 horizontal pair sums and needs
// no clearing after reset: every entry is used only after the row above wrote
// it. Sizes must be written through the configuration port only while the
// block is idle, which the block does not enforce. A size of zero acts as
// one, a size above the maximum acts as the maximum. Odd sizes above one drop
// the last column or row; level_done marks the last pixel of the reduced level.
module rgba8_box_downsample_2x2_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rgbds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rgbds_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  rgbds_pkg::texel_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output rgbds_pkg::result_t                out_data
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    rgbds_pkg::step_t step;
    logic [AW-1:0]    line_addr;
    logic             accept;
    logic             adv_out;

    // Pipeline control: stage one holds a result waiting for the line read,
    // the output register holds a result waiting for the consumer.
    logic s1_valid_reg;
    logic s1_valid_next;
    logic s1_dbl_reg;
    logic s1_last_reg;
    logic out_valid_reg;
    logic out_valid_next;
    logic last_reg;

    logic [rgbds_pkg::LINE_W-1:0] line_mem [LINE_DEPTH];
    logic [rgbds_pkg::LINE_W-1:0] line_rd_reg;
    logic [rgbds_pkg::LINE_W-1:0] pair_word;
    rgbds_pkg::texel_t            held_reg;

    logic [rgbds_pkg::CH_W-1:0] texel_b [rgbds_pkg::NUM_LANES];
    logic [rgbds_pkg::CH_W-1:0] held_b  [rgbds_pkg::NUM_LANES];
    logic [rgbds_pkg::CH_W-1:0] avg_b   [rgbds_pkg::NUM_LANES];

    // Advance the output register when empty or drained; stage one may then
    // move forward, and a new transaction may enter behind it in the same cycle.
    assign adv_out  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || adv_out;
    assign accept   = in_valid && in_ready;

    rgbds_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (accept),
        .step      (step),
        .line_addr (line_addr)
    );

    // Unpack channels so the lanes can be generated
    assign texel_b[0] = in_data.texel_c0;
    assign texel_b[1] = in_data.texel_c1;
    assign texel_b[2] = in_data.texel_c2;
    assign texel_b[3] = in_data.texel_c3;
    assign held_b[0]  = held_reg.texel_c0;
    assign held_b[1]  = held_reg.texel_c1;
    assign held_b[2]  = held_reg.texel_c2;
    assign held_b[3]  = held_reg.texel_c3;

    for (genvar i = 0; i < rgbds_pkg::NUM_LANES; i++)
    begin : g_lane
        rgbds_lane u_lane (
            .clk       (clk),
            .w_one     (step.w_one),
            .texel_b   (texel_b[i]),
            .held_b    (held_b[i]),
            .pair      (pair_word[i*rgbds_pkg::PAIR_W +: rgbds_pkg::PAIR_W]),
            .load_pair (accept),
            .load_avg  (adv_out),
            .dbl       (s1_dbl_reg),
            .line_pair (line_rd_reg[i*rgbds_pkg::PAIR_W +: rgbds_pkg::PAIR_W]),
            .avg       (avg_b[i])
        );
    end

    // Hold the even-column pixel until its right-hand partner arrives
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= '0;
        else if (accept && step.hold_en)
            held_reg <= in_data;
    end

    // Line store: even rows write pair sums, odd rows read them back. Read
    // data only changes on an accepted transaction, so it holds under stall.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (step.line_we)
                line_mem[line_addr] <= pair_word;
            line_rd_reg <= line_mem[line_addr];
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = step.emit;
        else if (adv_out)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (adv_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_dbl_reg  <= step.h_one;
            s1_last_reg <= step.last;
        end
        if (adv_out)
            last_reg <= s1_last_reg;
    end

    // Merge the lane results into one result transaction
    assign out_valid           = out_valid_reg;
    assign out_data.out_c0     = avg_b[0];
    assign out_data.out_c1     = avg_b[1];
    assign out_data.out_c2     = avg_b[2];
    assign out_data.out_c3     = avg_b[3];
    assign out_data.level_done = last_reg;

    // A pending stage-one result survives until the output register takes it
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !adv_out |=> s1_valid_reg)
        else $error("stage one result dropped while output stalled");

    // An empty stage one never blocks the input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stalled with empty pipeline");

    // A transaction either stores a pair sum or produces a result, never both
    a_we_emit: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !(step.line_we && step.emit))
        else $error("line write and result on one transaction");

    // A result-bearing transaction reaches stage one
    a_emit_fill: assert property (@(posedge clk) disable iff (!rst_n)
        accept && step.emit |=> s1_valid_reg)
        else $error("result lost on entry");

    // Output register is loaded only from a valid stage one
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg && !s1_valid_reg |=> !out_valid_reg)
        else $error("result invented at output");

endmodule
